// ----- rtl/core/gdr_pkg.sv -----
package gdr_pkg;

  localparam int unsigned QMAX       = 4194303;
  localparam logic [31:0] BLACK_CELL = 32'h000000FF;
  localparam int unsigned DIV_DW     = 64;
  localparam int unsigned DIV_SW     = 48;
  localparam int unsigned DIV_QW     = 32;

  localparam logic [2:0] CFG_MAP_W  = 3'd0;
  localparam logic [2:0] CFG_MAP_H  = 3'd1;
  localparam logic [2:0] CFG_RDIST  = 3'd2;
  localparam logic [2:0] CFG_FOCAL  = 3'd3;
  localparam logic [2:0] CFG_SCR_H  = 3'd4;

  typedef struct packed {
    logic               kind;
    logic [5:0]         cell_x;
    logic [5:0]         cell_y;
    logic [31:0]        cell_color;
    logic [21:0]        pos_x;
    logic [21:0]        pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic               side;
    logic [5:0]         hit_x;
    logic [5:0]         hit_y;
    logic [21:0]        ray_len;
    logic [11:0]        wall_h;
    logic signed [11:0] wall_top;
    logic [31:0]        shade_color;
  } out_item_t;

  typedef struct packed {
    logic       start;
    logic [5:0] qbits;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RX, S_RY, S_MX, S_MY, S_FX, S_FY, S_STEP, S_LOOK,
    S_NUM, S_DEN, S_CH, S_SHM, S_SHD, S_OUT
  } st_t;

endpackage

// ----- rtl/core/gdr_div.sv -----
module gdr_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  gdr_pkg::div_req_t                    req,
  input  logic [gdr_pkg::DIV_DW-1:0]           dividend,
  input  logic [gdr_pkg::DIV_SW-1:0]           divisor,
  output gdr_pkg::div_rsp_t                    rsp,
  output logic [gdr_pkg::DIV_QW-1:0]           quo,
  output logic [gdr_pkg::DIV_SW-1:0]           remd
);

  localparam int unsigned DW = gdr_pkg::DIV_DW;
  localparam int unsigned SW = gdr_pkg::DIV_SW;
  localparam int unsigned QW = gdr_pkg::DIV_QW;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          ovf_r, ovf_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] dvs_r, dvs_nxt;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] hi;
  logic [SW:0]   trial;
  logic          ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    hi       = dividend >> req.qbits;
    trial    = {rem_r, dvd_r[DW-1]};
    ge       = trial >= {1'b0, dvs_r};
    if (req.start) begin
      // quotient bits above qbits show up as overflow
      busy_nxt = 1'b1;
      ovf_nxt  = hi >= DW'(divisor);
      rem_nxt  = hi[SW-1:0];
      dvs_nxt  = divisor;
      dvd_nxt  = dividend << (7'd64 - {1'b0, req.qbits});
      cnt_nxt  = req.qbits;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? SW'(trial - {1'b0, dvs_r}) : trial[SW-1:0];
      quo_nxt = {quo_r[QW-2:0], ge};
      dvd_nxt = {dvd_r[DW-2:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    ovf_r <= ovf_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign quo      = quo_r;
  assign remd     = rem_r;

endmodule

// ----- rtl/core/grid_dda_raycast_column.sv -----
// grid raycaster for one screen column over a wrapped cell map
// input channel: in_valid / in_stall with in_data; kind 0 writes one map cell
// and gives no result, kind 1 casts a ray and gives exactly one result
// result channel: out_valid / out_stall with out_data; a miss has all fields zero
// cfg_we / cfg_addr / cfg_wdata write the five registers; the user writes them
// only while idle, which the block does not enforce; the block is ready again
// next cycle after a write request; a cast request keeps it busy through the
// reciprocals (skipped for a zero component), the start-cell wraps, the first
// boundary distances, the walk over the grid cells, the height, the shading and
// the load of the result, all divisions sharing one 1-bit-per-cycle divider and
// products sharing one 22x22 multiplier
// the result sits in an output register; while out_stall holds it the block
// finishes its cast and then waits, write requests are still taken when idle
// cells must be written before a ray reads them; the map is not cleared
// reset restores the register defaults and drops any pending result
module grid_dda_raycast_column #(
  parameter int unsigned MAP_SIDE = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gdr_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gdr_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [21:0]         cfg_wdata
);

  localparam int unsigned CW = $clog2(MAP_SIDE);
  localparam int unsigned SW = $clog2(MAP_SIDE + 1);
  localparam int unsigned AW = 2 * CW;

  // configuration
  logic [6:0]  map_w_r, map_h_r;
  logic [21:0] rdist_r, focal_r;
  logic [9:0]  scr_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r <= 7'd64;
      map_h_r <= 7'd64;
      rdist_r <= 22'd163840;
      focal_r <= 22'd327680;
      scr_h_r <= 10'd60;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        gdr_pkg::CFG_MAP_W: map_w_r <= cfg_wdata[6:0];
        gdr_pkg::CFG_MAP_H: map_h_r <= cfg_wdata[6:0];
        gdr_pkg::CFG_RDIST: rdist_r <= cfg_wdata;
        gdr_pkg::CFG_FOCAL: focal_r <= cfg_wdata;
        gdr_pkg::CFG_SCR_H: scr_h_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  gdr_pkg::st_t state_r, state_nxt;

  logic          in_acc;
  logic          issued_r, issued_nxt;
  logic [21:0]   px_r, px_nxt, py_r, py_nxt;
  logic [15:0]   drx_r, drx_nxt, dry_r, dry_nxt;
  logic          nx_r, nx_nxt, ny_r, ny_nxt;
  logic [21:0]   hx_r, hx_nxt, hy_r, hy_nxt;
  logic [SW-1:0] w_r, w_nxt, h_r, h_nxt;
  logic [CW-1:0] gx_r, gx_nxt, gy_r, gy_nxt;
  logic [23:0]   dx_r, dx_nxt, dy_r, dy_nxt;
  logic [21:0]   len_r, len_nxt;
  logic          side_r, side_nxt;
  logic          hit_r, hit_nxt;
  logic [31:0]   color_r, color_nxt;
  logic [31:0]   num_r, num_nxt;
  logic [43:0]   den_r, den_nxt;
  logic [11:0]   ch_r, ch_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic [30:0]   sp_r, sp_nxt;
  logic [31:0]   shade_r, shade_nxt;
  logic          ov_r, ov_nxt;
  gdr_pkg::out_item_t od_r, od_nxt;

  // divider and multiplier
  gdr_pkg::div_req_t             dreq;
  gdr_pkg::div_rsp_t             drsp;
  logic [gdr_pkg::DIV_DW-1:0]    dvd;
  logic [gdr_pkg::DIV_SW-1:0]    dvs;
  logic [gdr_pkg::DIV_QW-1:0]    quo;
  logic [gdr_pkg::DIV_SW-1:0]    remd;
  logic [21:0]                   mul_a, mul_b;
  logic [43:0]                   prod;

  gdr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dreq),
    .dividend (dvd),
    .divisor  (dvs),
    .rsp      (drsp),
    .quo      (quo),
    .remd     (remd)
  );

  assign prod = 44'(mul_a) * 44'(mul_b);

  // map store
  logic [31:0]   mem [0:(1 << AW)-1];
  logic [31:0]   rdata_r;
  logic [AW-1:0] raddr;
  logic [CW+5:0] wcx, wcy;
  logic          mem_we;

  assign wcx    = (CW + 6)'(in_data.cell_x);
  assign wcy    = (CW + 6)'(in_data.cell_y);
  assign mem_we = in_acc && !in_data.kind && (32'(in_data.cell_x) < MAP_SIDE)
                  && (32'(in_data.cell_y) < MAP_SIDE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{wcy[CW-1:0], wcx[CW-1:0]}] <= in_data.cell_color;
    end
    rdata_r <= mem[raddr];
  end

  // helpers
  logic [16:0]   magx, magy;
  logic [21:0]   qsat;
  logic [SW-1:0] w_c, h_c;
  logic [CW:0]   gx_inc, gy_inc;
  logic [CW-1:0] gx_step, gy_step;
  logic [23:0]   prev;
  logic [16:0]   fx, fy;
  logic [21:0]   rem_len;
  logic [7:0]    cbyte;
  logic signed [12:0] diff;
  logic signed [12:0] cstart;
  logic [CW+5:0] ogx, ogy;

  assign magx    = drx_r[15] ? 17'h10000 - {1'b0, drx_r} : {1'b0, drx_r};
  assign magy    = dry_r[15] ? 17'h10000 - {1'b0, dry_r} : {1'b0, dry_r};
  assign qsat    = (quo > 32'(gdr_pkg::QMAX)) ? 22'(gdr_pkg::QMAX) : quo[21:0];
  assign w_c     = (map_w_r == 7'd0) ? SW'(1) :
                   ((32'(map_w_r) > MAP_SIDE) ? SW'(MAP_SIDE) : SW'(map_w_r));
  assign h_c     = (map_h_r == 7'd0) ? SW'(1) :
                   ((32'(map_h_r) > MAP_SIDE) ? SW'(MAP_SIDE) : SW'(map_h_r));
  assign gx_inc  = (CW + 1)'(gx_r) + (CW + 1)'(1);
  assign gy_inc  = (CW + 1)'(gy_r) + (CW + 1)'(1);
  assign fx      = nx_r ? {1'b0, px_r[15:0]} : 17'h10000 - {1'b0, px_r[15:0]};
  assign fy      = ny_r ? {1'b0, py_r[15:0]} : 17'h10000 - {1'b0, py_r[15:0]};
  assign rem_len = rdist_r - len_r;
  assign diff    = $signed({3'b000, scr_h_r}) - $signed({1'b0, ch_r});
  assign cstart  = (diff >= 0) ? ((diff + 13'sd1) >>> 1) : -((-diff + 13'sd1) >>> 1);
  assign ogx     = (CW + 6)'(gx_r);
  assign ogy     = (CW + 6)'(gy_r);

  always_comb begin
    case (idx_r)
      2'd0:    cbyte = color_r[31:24];
      2'd1:    cbyte = color_r[23:16];
      2'd2:    cbyte = color_r[15:8];
      default: cbyte = color_r[7:0];
    endcase
  end

  always_comb begin
    if (nx_r) begin
      gx_step = (gx_r == '0) ? CW'(w_r - SW'(1)) : gx_r - CW'(1);
    end else begin
      gx_step = (SW'(gx_inc) >= w_r) ? '0 : gx_inc[CW-1:0];
    end
    if (ny_r) begin
      gy_step = (gy_r == '0) ? CW'(h_r - SW'(1)) : gy_r - CW'(1);
    end else begin
      gy_step = (SW'(gy_inc) >= h_r) ? '0 : gy_inc[CW-1:0];
    end
  end

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    state_nxt  = state_r;
    issued_nxt = issued_r;
    px_nxt = px_r;  py_nxt = py_r;
    drx_nxt = drx_r; dry_nxt = dry_r;
    nx_nxt = nx_r;  ny_nxt = ny_r;
    hx_nxt = hx_r;  hy_nxt = hy_r;
    w_nxt = w_r;    h_nxt = h_r;
    gx_nxt = gx_r;  gy_nxt = gy_r;
    dx_nxt = dx_r;  dy_nxt = dy_r;
    len_nxt = len_r; side_nxt = side_r; hit_nxt = hit_r;
    color_nxt = color_r; num_nxt = num_r; den_nxt = den_r; ch_nxt = ch_r;
    idx_nxt = idx_r; sp_nxt = sp_r; shade_nxt = shade_r;
    ov_nxt = ov_r;
    od_nxt = od_r;
    dreq.start = 1'b0;
    dreq.qbits = 6'd1;
    dvd   = '0;
    dvs   = '0;
    mul_a = '0;
    mul_b = '0;
    prev  = '0;
    raddr = {gy_r, gx_r};
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      gdr_pkg::S_IDLE: begin
        if (in_acc && in_data.kind) begin
          px_nxt  = in_data.pos_x;
          py_nxt  = in_data.pos_y;
          drx_nxt = in_data.dir_x;
          dry_nxt = in_data.dir_y;
          nx_nxt  = in_data.dir_x[15];
          ny_nxt  = in_data.dir_y[15];
          w_nxt   = w_c;
          h_nxt   = h_c;
          hit_nxt = 1'b0;
          state_nxt = gdr_pkg::S_RX;
        end
      end
      gdr_pkg::S_RX, gdr_pkg::S_RY: begin
        dvd        = 64'h40000000;
        dvs        = 48'((state_r == gdr_pkg::S_RX) ? magx : magy);
        dreq.qbits = 6'd31;
        if (dvs == '0) begin
          // zero component: saturated step length
          if (state_r == gdr_pkg::S_RX) begin
            hx_nxt = 22'(gdr_pkg::QMAX);
            state_nxt = gdr_pkg::S_RY;
          end else begin
            hy_nxt = 22'(gdr_pkg::QMAX);
            state_nxt = gdr_pkg::S_MX;
          end
        end else if (!issued_r) begin
          dreq.start = 1'b1;
          issued_nxt = 1'b1;
        end else if (drsp.done) begin
          issued_nxt = 1'b0;
          if (state_r == gdr_pkg::S_RX) begin
            hx_nxt = qsat;
            state_nxt = gdr_pkg::S_RY;
          end else begin
            hy_nxt = qsat;
            state_nxt = gdr_pkg::S_MX;
          end
        end
      end
      gdr_pkg::S_MX, gdr_pkg::S_MY: begin
        dvd        = 64'((state_r == gdr_pkg::S_MX) ? px_r[21:16] : py_r[21:16]);
        dvs        = 48'((state_r == gdr_pkg::S_MX) ? w_r : h_r);
        dreq.qbits = 6'd6;
        if (!issued_r) begin
          dreq.start = 1'b1;
          issued_nxt = 1'b1;
        end else if (drsp.done) begin
          issued_nxt = 1'b0;
          if (state_r == gdr_pkg::S_MX) begin
            gx_nxt = CW'(remd);
            state_nxt = gdr_pkg::S_MY;
          end else begin
            gy_nxt = CW'(remd);
            state_nxt = gdr_pkg::S_FX;
          end
        end
      end
      gdr_pkg::S_FX: begin
        mul_a  = 22'(fx);
        mul_b  = hx_r;
        dx_nxt = 24'(prod[43:16]);
        state_nxt = gdr_pkg::S_FY;
      end
      gdr_pkg::S_FY: begin
        mul_a  = 22'(fy);
        mul_b  = hy_r;
        dy_nxt = 24'(prod[43:16]);
        state_nxt = gdr_pkg::S_STEP;
      end
      gdr_pkg::S_STEP: begin
        // advance along the nearer boundary, ties go to y
        if (dx_r < dy_r) begin
          prev     = dx_r;
          dx_nxt   = dx_r + 24'(hx_r);
          gx_nxt   = gx_step;
          side_nxt = 1'b0;
        end else begin
          prev     = dy_r;
          dy_nxt   = dy_r + 24'(hy_r);
          gy_nxt   = gy_step;
          side_nxt = 1'b1;
        end
        raddr   = {gy_nxt, gx_nxt};
        len_nxt = prev[21:0];
        if (prev >= 24'(rdist_r)) begin
          state_nxt = gdr_pkg::S_OUT;
        end else begin
          state_nxt = gdr_pkg::S_LOOK;
        end
      end
      gdr_pkg::S_LOOK: begin
        if (rdata_r != gdr_pkg::BLACK_CELL) begin
          hit_nxt   = 1'b1;
          color_nxt = rdata_r;
          state_nxt = gdr_pkg::S_NUM;
        end else begin
          state_nxt = gdr_pkg::S_STEP;
        end
      end
      gdr_pkg::S_NUM: begin
        mul_a   = 22'(scr_h_r);
        mul_b   = rdist_r;
        num_nxt = prod[31:0];
        state_nxt = gdr_pkg::S_DEN;
      end
      gdr_pkg::S_DEN: begin
        mul_a   = len_r;
        mul_b   = focal_r;
        den_nxt = prod;
        state_nxt = gdr_pkg::S_CH;
      end
      gdr_pkg::S_CH: begin
        // round half up: (2^17 num + den) / (2 den)
        dvd        = {num_r, 17'd0} + 64'(den_r);
        dvs        = {3'd0, den_r, 1'b0};
        dreq.qbits = 6'd12;
        if (den_r == '0) begin
          ch_nxt  = 12'hFFF;
          idx_nxt = 2'd0;
          state_nxt = gdr_pkg::S_SHM;
        end else if (!issued_r) begin
          dreq.start = 1'b1;
          issued_nxt = 1'b1;
        end else if (drsp.done) begin
          issued_nxt = 1'b0;
          ch_nxt  = drsp.ovf ? 12'hFFF : quo[11:0];
          idx_nxt = 2'd0;
          state_nxt = gdr_pkg::S_SHM;
        end
      end
      gdr_pkg::S_SHM: begin
        mul_a  = 22'(cbyte);
        mul_b  = rem_len;
        sp_nxt = 31'(prod[29:0]);
        if (idx_r == 2'd3) begin
          // alpha leans toward opaque
          sp_nxt = 31'(prod[29:0]) + ({1'b0, len_r, 8'd0} - 31'(len_r));
        end
        state_nxt = gdr_pkg::S_SHD;
      end
      gdr_pkg::S_SHD: begin
        dvd        = 64'(sp_r);
        dvs        = 48'(rdist_r);
        dreq.qbits = 6'd8;
        if (!issued_r) begin
          dreq.start = 1'b1;
          issued_nxt = 1'b1;
        end else if (drsp.done) begin
          issued_nxt = 1'b0;
          shade_nxt  = {shade_r[23:0], quo[7:0]};
          idx_nxt    = idx_r + 2'd1;
          state_nxt  = (idx_r == 2'd3) ? gdr_pkg::S_OUT : gdr_pkg::S_SHM;
        end
      end
      gdr_pkg::S_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          od_nxt = '0;
          if (hit_r) begin
            od_nxt.hit         = 1'b1;
            od_nxt.side        = side_r;
            od_nxt.hit_x       = ogx[5:0];
            od_nxt.hit_y       = ogy[5:0];
            od_nxt.ray_len     = len_r;
            od_nxt.wall_h      = ch_r;
            od_nxt.wall_top    = cstart[11:0];
            od_nxt.shade_color = shade_r;
          end
          state_nxt = gdr_pkg::S_IDLE;
        end
      end
      default: state_nxt = gdr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= gdr_pkg::S_IDLE;
      issued_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
      ov_r     <= ov_nxt;
    end
    px_r <= px_nxt;  py_r <= py_nxt;
    drx_r <= drx_nxt; dry_r <= dry_nxt;
    nx_r <= nx_nxt;  ny_r <= ny_nxt;
    hx_r <= hx_nxt;  hy_r <= hy_nxt;
    w_r <= w_nxt;    h_r <= h_nxt;
    gx_r <= gx_nxt;  gy_r <= gy_nxt;
    dx_r <= dx_nxt;  dy_r <= dy_nxt;
    len_r <= len_nxt; side_r <= side_nxt; hit_r <= hit_nxt;
    color_r <= color_nxt; num_r <= num_nxt; den_r <= den_nxt; ch_r <= ch_nxt;
    idx_r <= idx_nxt; sp_r <= sp_nxt; shade_r <= shade_nxt;
    od_r <= od_nxt;
  end

  assign in_stall  = (state_r != gdr_pkg::S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  a_div_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> (state_r == gdr_pkg::S_RX || state_r == gdr_pkg::S_RY ||
                   state_r == gdr_pkg::S_MX || state_r == gdr_pkg::S_MY ||
                   state_r == gdr_pkg::S_CH || state_r == gdr_pkg::S_SHD))
    else $error("divider finished outside a division step");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !od_r.hit) |-> (od_r == '0))
    else $error("miss request carries nonzero fields");

  a_look_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gdr_pkg::S_LOOK) |-> ($past(state_r) == gdr_pkg::S_STEP))
    else $error("cell check without a grid step");

endmodule
